### hdl/hrhp_pkg.sv
package hrhp_pkg;

  localparam logic [7:0] LF_CHAR    = 8'h0a;
  localparam logic [7:0] CR_CHAR    = 8'h0d;
  localparam logic [7:0] SPACE_CHAR = 8'h20;
  localparam logic [7:0] COLON_CHAR = 8'h3a;
  localparam logic [7:0] DOT_CHAR   = 8'h2e;
  localparam logic [7:0] ZERO_CHAR  = 8'h30;
  localparam logic [7:0] NINE_CHAR  = 8'h39;

  // Only the first seven method bytes are ever compared against the names.
  localparam int unsigned METHOD_MAX_CHARS = 7;
  localparam int unsigned METHOD_STORE     = (METHOD_MAX_CHARS < 7) ? METHOD_MAX_CHARS : 7;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    EV_PATH_BYTE,
    EV_REQ_LINE_OK,
    EV_NAME_BYTE,
    EV_VALUE_BYTE,
    EV_HEADER_END,
    EV_COMPLETE,
    EV_INVALID
  } event_kind_e;

  localparam logic [3:0] METHOD_UNKNOWN = 4'd8;

  // Method names with the first byte in the low bits, zero padded.
  localparam logic [55:0] METHOD_NAMES [8] = '{
    {32'h0, "T", "E", "G"},
    {24'h0, "D", "A", "E", "H"},
    {24'h0, "T", "S", "O", "P"},
    {32'h0, "T", "U", "P"},
    {8'h0, "E", "T", "E", "L", "E", "D"},
    {16'h0, "E", "C", "A", "R", "T"},
    {"S", "N", "O", "I", "T", "P", "O"},
    {"T", "C", "E", "N", "N", "O", "C"}
  };
  localparam logic [3:0] METHOD_LENS [8] = '{4'd3, 4'd4, 4'd4, 4'd3, 4'd6, 4'd5, 4'd7, 4'd7};

  localparam logic [31:0] PROTO_PREFIX = "HTTP";

  // Request line: token 0 method, 1 path, 2 version.
  // Header line: token 0 name, 1 spaces before value, 2 value.
  typedef struct packed {
    logic        line_phase;
    logic [1:0]  token_phase;
    logic [55:0] method_chars;
    logic [3:0]  method_count;
    logic [2:0]  version_offset;
    logic        prefix_good;
    logic        dot_found;
    logic [15:0] major_value;
    logic [15:0] minor_value;
    logic [1:0]  digits_active;
    logic        line_nonempty;
  } state_t;

  localparam state_t STATE_CLEAR = '{
    line_phase:     1'b0,
    token_phase:    2'd0,
    method_chars:   56'h0,
    method_count:   4'd0,
    version_offset: 3'd0,
    prefix_good:    1'b1,
    dot_found:      1'b0,
    major_value:    16'h0,
    minor_value:    16'h0,
    digits_active:  2'b00,
    line_nonempty:  1'b0
  };

  typedef struct packed {
    event_kind_e kind;
    logic [7:0]  data;
    logic [3:0]  method;
    logic [15:0] major;
    logic [15:0] minor;
    logic        last;
  } result_t;

  typedef struct packed {
    state_t  st;
    logic    emit;
    result_t res;
  } step_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

  function automatic logic [3:0] method_of(logic [55:0] chars, logic [3:0] count);
    logic [3:0] code;
    code = METHOD_UNKNOWN;
    for (int k = 7; k >= 0; k--) begin
      if (count == METHOD_LENS[k] && chars == METHOD_NAMES[k]) begin
        code = 4'(k);
      end
    end
    return code;
  endfunction

  function automatic logic [15:0] add_digit(logic [15:0] v, logic [7:0] c);
    logic [19:0] t;
    t = {1'b0, v, 3'b000} + {3'b000, v, 1'b0} + {16'h0, c[3:0]};
    return (t > 20'd65535) ? 16'hffff : t[15:0];
  endfunction

  function automatic result_t make_result(event_kind_e kind, logic [7:0] data);
    result_t r;
    r = '0;
    r.kind = kind;
    r.data = data;
    return r;
  endfunction

  function automatic state_t version_byte(state_t s, logic [7:0] c);
    state_t n;
    logic   digit;
    n = s;
    digit = (c >= ZERO_CHAR) && (c <= NINE_CHAR);
    if (s.version_offset < 3'd4 &&
        c != PROTO_PREFIX[31 - 8 * s.version_offset[1:0] -: 8]) begin
      n.prefix_good = 1'b0;
    end
    if (s.version_offset == 3'd5) begin
      n.digits_active[0] = 1'b1;
    end
    if (n.digits_active[0]) begin
      if (digit) n.major_value = add_digit(s.major_value, c);
      else n.digits_active[0] = 1'b0;
    end
    if (n.digits_active[1]) begin
      if (digit) n.minor_value = add_digit(s.minor_value, c);
      else n.digits_active[1] = 1'b0;
    end
    if (!s.dot_found && c == DOT_CHAR) begin
      n.dot_found        = 1'b1;
      n.digits_active[1] = 1'b1;
    end
    if (s.version_offset < 3'd7) begin
      n.version_offset = s.version_offset + 3'd1;
    end
    return n;
  endfunction

  function automatic step_t data_byte(state_t s, logic [7:0] c);
    step_t r;
    r.st   = s;
    r.emit = 1'b0;
    r.res  = make_result(EV_PATH_BYTE, c);
    r.st.line_nonempty = 1'b1;
    if (!s.line_phase) begin
      case (s.token_phase)
        2'd0: begin
          if (c == SPACE_CHAR) begin
            r.st.token_phase = 2'd1;
          end else begin
            if (s.method_count < 4'(METHOD_STORE)) begin
              r.st.method_chars[8 * s.method_count[2:0] +: 8] = c;
            end
            if (s.method_count != 4'd15) begin
              r.st.method_count = s.method_count + 4'd1;
            end
          end
        end
        2'd1: begin
          if (c == SPACE_CHAR) r.st.token_phase = 2'd2;
          else r.emit = 1'b1;
        end
        default: begin
          r.st = version_byte(r.st, c);
        end
      endcase
    end else begin
      case (s.token_phase)
        2'd0: begin
          if (c == COLON_CHAR) begin
            r.st.token_phase = 2'd1;
          end else begin
            r.emit = 1'b1;
            r.res  = make_result(EV_NAME_BYTE, c);
          end
        end
        2'd1: begin
          if (c != SPACE_CHAR) begin
            r.st.token_phase = 2'd2;
            r.emit = 1'b1;
            r.res  = make_result(EV_VALUE_BYTE, c);
          end
        end
        default: begin
          r.emit = 1'b1;
          r.res  = make_result(EV_VALUE_BYTE, c);
        end
      endcase
    end
    return r;
  endfunction

  function automatic step_t line_end(state_t s);
    step_t   r;
    result_t info;
    info        = '0;
    info.method = method_of(s.method_chars, s.method_count);
    info.major  = s.major_value;
    info.minor  = s.minor_value;
    r.st   = s;
    r.emit = 1'b1;
    r.res  = make_result(EV_INVALID, 8'h00);
    if (!s.line_phase) begin
      if (s.token_phase >= 2'd2 && s.prefix_good && s.version_offset >= 3'd4 &&
          s.dot_found) begin
        r.res      = info;
        r.res.kind = EV_REQ_LINE_OK;
        r.st.line_phase    = 1'b1;
        r.st.token_phase   = 2'd0;
        r.st.line_nonempty = 1'b0;
      end else begin
        r.st = STATE_CLEAR;
      end
    end else if (!s.line_nonempty) begin
      r.res      = info;
      r.res.kind = EV_COMPLETE;
      r.st       = STATE_CLEAR;
    end else if (s.token_phase == 2'd0) begin
      r.st = STATE_CLEAR;
    end else begin
      r.res      = info;
      r.res.kind = EV_HEADER_END;
      r.st.token_phase   = 2'd0;
      r.st.line_nonempty = 1'b0;
    end
    return r;
  endfunction

endpackage

### hdl/hrhp_core.sv
module hrhp_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [7:0]       byte_i,
  output hrhp_pkg::push_t  push_o
);
  import hrhp_pkg::*;

  state_t state_q, state_d;
  logic   held_cr_q, held_cr_d;
  step_t  step_a, step_b;
  push_t  push;

  always_comb begin
    state_d   = state_q;
    held_cr_d = held_cr_q;
    step_a    = '0;
    step_b    = '0;
    if (byte_i == LF_CHAR) begin
      held_cr_d = 1'b0;
      step_b    = line_end(state_q);
      state_d   = step_b.st;
    end else begin
      step_a.st = state_q;
      // A held CR that is not followed by LF is ordinary data, handled first.
      if (held_cr_q) begin
        held_cr_d = 1'b0;
        step_a    = data_byte(state_q, CR_CHAR);
      end
      state_d = step_a.st;
      if (byte_i == CR_CHAR) begin
        held_cr_d = 1'b1;
      end else begin
        step_b  = data_byte(step_a.st, byte_i);
        state_d = step_b.st;
      end
    end
  end

  always_comb begin
    push        = '0;
    push.count  = {1'b0, step_a.emit} + {1'b0, step_b.emit};
    push.first  = step_a.emit ? step_a.res : step_b.res;
    push.second = step_b.res;
    if (step_a.emit && step_b.emit) begin
      push.second.last = 1'b1;
    end else begin
      push.first.last = 1'b1;
    end
    if (!accept_i) begin
      push.count = 2'd0;
    end
  end

  assign push_o = push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= STATE_CLEAR;
      held_cr_q <= 1'b0;
    end else if (accept_i) begin
      state_q   <= state_d;
      held_cr_q <= held_cr_d;
    end
  end

endmodule

### hdl/hrhp_result_queue.sv
module hrhp_result_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  hrhp_pkg::push_t   push_i,
  input  logic              pop_i,
  output hrhp_pkg::result_t head_o,
  output logic              nonempty_o,
  output logic              room_for_two_o
);
  import hrhp_pkg::*;

  result_t                  mem_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QUEUE_PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QUEUE_CNT_W-1:0]   count_q, count_d;
  logic [QUEUE_PTR_W-1:0]   wr_next;
  logic                     do_pop;

  assign nonempty_o     = (count_q != '0);
  assign room_for_two_o = (count_q <= QUEUE_CNT_W'(QUEUE_DEPTH - 2));
  assign head_o         = mem_q[rd_ptr_q];
  assign do_pop         = pop_i && nonempty_o;
  assign wr_next        = wr_ptr_q + QUEUE_PTR_W'(1);

  always_comb begin
    wr_ptr_d = wr_ptr_q + QUEUE_PTR_W'(push_i.count);
    rd_ptr_d = rd_ptr_q + QUEUE_PTR_W'(do_pop);
    count_d  = count_q + QUEUE_CNT_W'(push_i.count) - QUEUE_CNT_W'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.first;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_next] <= push_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

### hdl/http_request_head_parser_top.sv
// HTTP/1.x request head parser.
// The input channel (in_valid_i, in_ready_o, byte_in_i) takes one raw byte of
// the request stream per transaction. The output channel (out_valid_o,
// out_ready_i and the result fields) gives one parse event per transaction.
// A byte gives zero, one or two events; last_of_step_o marks the final event
// caused by a byte. A CR is held back until the next byte shows whether it
// ends a line, so its events appear with the following byte.
// Each accepted byte updates the parse state; its events go into a four-entry
// result queue and are offered on the output, behind earlier events, from the
// cycle after acceptance. A byte can be taken every cycle while in_ready_o is
// high. in_ready_o is high while the queue has room for two events; when the
// receiver stalls the queue fills and in_ready_o drops until entries are
// taken, with no event lost. Reset empties the queue, drops any held CR and
// returns the parser to the start of a request line.
module http_request_head_parser_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  byte_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  event_kind_o,
  output logic [7:0]  byte_out_o,
  output logic [3:0]  method_code_o,
  output logic [15:0] version_major_o,
  output logic [15:0] version_minor_o,
  output logic        last_of_step_o
);
  import hrhp_pkg::*;

  push_t   push;
  result_t head;
  logic    room_for_two;
  logic    accept;

  assign in_ready_o = room_for_two;
  assign accept     = in_valid_i && room_for_two;

  hrhp_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .byte_i   (byte_in_i),
    .push_o   (push)
  );

  hrhp_result_queue u_queue (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .pop_i          (out_ready_i),
    .head_o         (head),
    .nonempty_o     (out_valid_o),
    .room_for_two_o (room_for_two)
  );

  assign event_kind_o    = head.kind;
  assign byte_out_o      = head.data;
  assign method_code_o   = head.method;
  assign version_major_o = head.major;
  assign version_minor_o = head.minor;
  assign last_of_step_o  = head.last;

endmodule
